/* design/sds_pkg.sv */
// Shared types and constants for the stokeslet direct-sum block.
// No dependencies; compile this file first.
package sds_pkg;

  localparam int DATA_W     = 32;  // Q.FRAC input words
  localparam int VEL_W      = 48;  // Q32.FRAC result words
  localparam int ACC_W      = 64;  // running sums
  localparam int DIV_W      = 64;  // shared divider width
  localparam int U_ONE_BITS = 30;  // unit vector is Q1.30
  localparam int E_W        = 30;  // scaled displacement magnitude
  localparam int MUL_A_W    = 35;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [MUL_A_W-1:0] INV_8PI_Q32 = MUL_A_W'(170891319);
  localparam logic [VEL_W-1:0]   VEL_MAX     = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0]   VEL_MIN     = {1'b1, {(VEL_W-1){1'b0}}};

endpackage

/* design/sds_ifaces.sv */
// Valid/ready channel interfaces for the stokeslet direct-sum block.
// Depends on sds_pkg for the field widths.
interface sds_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sds_pkg::DATA_W-1:0]   target_x;
  logic signed [sds_pkg::DATA_W-1:0]   target_y;
  logic signed [sds_pkg::DATA_W-1:0]   target_z;
  logic signed [sds_pkg::DATA_W-1:0]   source_x;
  logic signed [sds_pkg::DATA_W-1:0]   source_y;
  logic signed [sds_pkg::DATA_W-1:0]   source_z;
  logic        [sds_pkg::DATA_W-1:0]   weight_area;
  logic signed [sds_pkg::DATA_W-1:0]   force_x;
  logic signed [sds_pkg::DATA_W-1:0]   force_y;
  logic signed [sds_pkg::DATA_W-1:0]   force_z;
  logic                                last_point;

  modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, weight_area, force_x, force_y, force_z, last_point,
                  input ready);
  modport sink   (input valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, weight_area, force_x, force_y, force_z, last_point,
                  output ready);
endinterface

interface sds_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sds_pkg::VEL_W-1:0]   vel_x;
  logic signed [sds_pkg::VEL_W-1:0]   vel_y;
  logic signed [sds_pkg::VEL_W-1:0]   vel_z;
  logic                               saturated;
  logic                               zero_distance;

  modport source (output valid, vel_x, vel_y, vel_z, saturated, zero_distance,
                  input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, saturated, zero_distance,
                  output ready);
endinterface

/* design/sds_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on sds_pkg for its width.
module sds_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sds_pkg::DIV_W-1:0]   dividend,
  input  logic [sds_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [sds_pkg::DIV_W-1:0]   quotient
);

  localparam int W   = sds_pkg::DIV_W;
  localparam int C_W = $clog2(W);
  localparam logic [C_W-1:0] LAST_STEP = C_W'(W - 1);

  logic [W-1:0]   rem_r, quo_r, div_r;
  logic [C_W-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [W:0]     shifted, diff;
  logic           fits;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, div_r};
    fits    = shifted >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/stokeslet_direct_sum_core.sv */
// Stokeslet single-layer direct summation core.
// A non-final point keeps ready low from acceptance until its term is added to the sums;
// a final point then runs the velocity scaling before its result transaction is presented.
// Points are taken one at a time; the 64-step shared divider is used four times per point.
// A coincident point adds no term. Reset (rst_n low, synchronous) clears sums and flags.
// Depends on sds_pkg, sds_ifaces and sds_div.
module stokeslet_direct_sum_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  sds_in_if.sink        in_chan,
  sds_out_if.source     out_chan
);

  localparam int DW = sds_pkg::DATA_W;
  localparam int AW = sds_pkg::ACC_W;
  localparam int VW = sds_pkg::VEL_W;
  localparam int PW = sds_pkg::PROD_W;
  localparam int EW = sds_pkg::E_W;
  localparam int UB = sds_pkg::U_ONE_BITS;
  localparam int FW = PW + 32;  // two partial products joined

  // The sequencer walks every non-coincident point through the same steps. The
  // shared multiplier has a registered product, so each partial product takes an
  // issue state and a consume state. Divisions run on the shared divider.
  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SCALE, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_UDIV, S_UWAIT,
    S_FU_MUL, S_FU_ACC, S_FU_FIN, S_G_MUL, S_G_ACC, S_HDIV, S_HWAIT,
    S_T_LO, S_T_HI, S_T_ACC, S_V_LO, S_V_HI, S_V_ACC, S_EMIT
  } state_t;

  state_t state_r;
  logic [1:0] idx_r;

  // Captured transaction.
  logic signed [DW-1:0] tgt_r [3];
  logic signed [DW-1:0] src_r [3];
  logic signed [DW-1:0] f_r [3];
  logic [DW-1:0]        area_r;
  logic                 last_r;

  // Kernel working registers.
  logic signed [DW:0]   d_r [3];
  logic [EW-1:0]        emag_r [3];
  logic                 eneg_r [3];
  logic [1:0]           s_r;
  logic [AW-1:0]        r2_r, sqv_r, sqres_r, sqbit_r;
  logic [30:0]          re_r;
  logic [30:0]          umag_r [3];
  logic signed [AW-1:0] fu_acc_r;
  logic [32:0]          fu_mag_r;
  logic                 fu_neg_r;
  logic signed [34:0]   g_r [3];
  logic [AW-1:0]        h_r;
  logic [PW-1:0]        mul_p_r, plo_r;

  // Architectural state.
  logic signed [AW-1:0] sum_r [3];
  logic                 clip_seen_r, coincide_seen_r;

  // Result register.
  logic                 out_valid_r;
  logic [VW-1:0]        vel_r [3];
  logic [VW-1:0]        vout_r [3];
  logic                 sat_out_r, zd_out_r;

  // Displacement magnitudes and the pre-shift that keeps them under 2^30.
  logic [DW:0]   dmag [3];
  logic [DW:0]   mmax;
  logic [1:0]    s_w;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = d_r[i][DW] ? (DW+1)'(-d_r[i]) : d_r[i];
    end
    mmax = dmag[0];
    if (dmag[1] > mmax) mmax = dmag[1];
    if (dmag[2] > mmax) mmax = dmag[2];
    if (mmax[32])      s_w = 2'd3;
    else if (mmax[31]) s_w = 2'd2;
    else if (mmax[30]) s_w = 2'd1;
    else               s_w = 2'd0;
  end

  // Magnitudes of operands selected by the current index.
  logic [31:0]   fmag;
  logic [34:0]   gmag;
  logic [AW-1:0] smag;
  always_comb begin
    fmag = f_r[idx_r][DW-1] ? 32'(-f_r[idx_r]) : 32'(f_r[idx_r]);
    gmag = g_r[idx_r][34] ? 35'(-g_r[idx_r]) : 35'(g_r[idx_r]);
    smag = sum_r[idx_r][AW-1] ? AW'(-sum_r[idx_r]) : AW'(sum_r[idx_r]);
  end

  // Shared multiplier operand selection.
  logic [sds_pkg::MUL_A_W-1:0] mul_a;
  logic [sds_pkg::MUL_B_W-1:0] mul_b;
  always_comb begin
    case (state_r)
      S_SQ_MUL: begin mul_a = 35'(emag_r[idx_r]); mul_b = 32'(emag_r[idx_r]); end
      S_FU_MUL: begin mul_a = 35'(fmag);          mul_b = 32'(umag_r[idx_r]); end
      S_G_MUL:  begin mul_a = 35'(fu_mag_r);      mul_b = 32'(umag_r[idx_r]); end
      S_T_LO:   begin mul_a = gmag;               mul_b = h_r[31:0];          end
      S_T_HI:   begin mul_a = gmag;               mul_b = h_r[63:32];         end
      S_V_LO:   begin mul_a = sds_pkg::INV_8PI_Q32; mul_b = smag[31:0];       end
      S_V_HI:   begin mul_a = sds_pkg::INV_8PI_Q32; mul_b = smag[63:32];      end
      default:  begin mul_a = '0;                 mul_b = '0;                 end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= PW'(mul_a) * PW'(mul_b);
  end

  // Shared divider: unit vector components and the area-over-distance factor.
  logic          div_start, div_done;
  logic [AW-1:0] div_num, div_den, div_quo;
  always_comb begin
    div_start = (state_r == S_UDIV) || (state_r == S_HDIV);
    if (state_r == S_HDIV) begin
      div_num = AW'(area_r) << FRAC_BITS;
      div_den = AW'(re_r) << s_r;
    end else begin
      div_num = AW'(emag_r[idx_r]) << UB;
      div_den = AW'(re_r);
    end
  end

  sds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Square root step.
  logic [AW-1:0] sq_trial;
  assign sq_trial = sqres_r + sqbit_r;

  // Dot-product accumulation and the correction term of g.
  logic [AW-1:0]        fu_abs;
  logic [36:0]          gq;
  logic signed [34:0]   g_new;
  always_comb begin
    fu_abs = fu_acc_r[AW-1] ? AW'(-fu_acc_r) : AW'(fu_acc_r);
    gq     = mul_p_r[PW-1:UB];
    g_new  = 35'(f_r[idx_r]) +
             ((fu_neg_r ^ eneg_r[idx_r]) ? -35'(gq) : 35'(gq));
  end

  // Join the two partial products of a 64-bit multiply.
  logic [FW-1:0] full;
  assign full = {mul_p_r, 32'b0} + FW'(plo_r);

  // Term scaling, clip to +-(2^63-1) and saturating add.
  logic [FW-1:0]        tsh;
  logic                 tclip;
  logic [AW-2:0]        tmag;
  logic signed [AW-1:0] term;
  logic [AW:0]          s65;
  logic                 sovf;
  logic signed [AW-1:0] sum_new;
  always_comb begin
    tsh     = full >> FRAC_BITS;
    tclip   = |tsh[FW-1:AW-1];
    tmag    = tclip ? {(AW-1){1'b1}} : tsh[AW-2:0];
    term    = g_r[idx_r][34] ? -{1'b0, tmag} : {1'b0, tmag};
    s65     = {sum_r[idx_r][AW-1], sum_r[idx_r]} + {term[AW-1], term};
    sovf    = s65[AW] ^ s65[AW-1];
    sum_new = sovf ? (s65[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}})
                   : s65[AW-1:0];
  end

  // Velocity scaling and clamp to the 48-bit signed range.
  logic [FW-33:0] vmag;
  logic           vneg, vclip;
  logic [VW-1:0]  vel_new;
  always_comb begin
    vmag = full[FW-1:32];
    vneg = sum_r[idx_r][AW-1];
    if (!vneg && vmag > (FW-32)'(sds_pkg::VEL_MAX)) begin
      vclip = 1'b1; vel_new = sds_pkg::VEL_MAX;
    end else if (vneg && vmag > (FW-32)'(sds_pkg::VEL_MIN)) begin
      vclip = 1'b1; vel_new = sds_pkg::VEL_MIN;
    end else begin
      vclip   = 1'b0;
      vel_new = vneg ? VW'(-vmag) : VW'(vmag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
      clip_seen_r     <= 1'b0;
      coincide_seen_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      // The emit state decides the output valid on its own.
      if (out_chan.ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            tgt_r[0] <= in_chan.target_x; tgt_r[1] <= in_chan.target_y;
            tgt_r[2] <= in_chan.target_z;
            src_r[0] <= in_chan.source_x; src_r[1] <= in_chan.source_y;
            src_r[2] <= in_chan.source_z;
            f_r[0]   <= in_chan.force_x;  f_r[1]   <= in_chan.force_y;
            f_r[2]   <= in_chan.force_z;
            area_r   <= in_chan.weight_area;
            last_r   <= in_chan.last_point;
            state_r  <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            d_r[i] <= (DW+1)'(tgt_r[i]) - (DW+1)'(src_r[i]);
          end
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          // A point on top of the target contributes nothing.
          if (mmax == '0) begin
            coincide_seen_r <= 1'b1;
            idx_r   <= '0;
            state_r <= last_r ? S_V_LO : S_IDLE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              emag_r[i] <= EW'(dmag[i] >> s_w);
              eneg_r[i] <= d_r[i][DW];
            end
            s_r     <= s_w;
            r2_r    <= '0;
            idx_r   <= '0;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          r2_r <= r2_r + AW'(mul_p_r);
          if (idx_r == 2'd2) begin
            sqv_r   <= r2_r + AW'(mul_p_r);
            sqres_r <= '0;
            sqbit_r <= AW'(1) << (AW - 2);
            state_r <= S_SQRT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQRT: begin
          if (sqbit_r == '0) begin
            re_r    <= sqres_r[30:0];
            idx_r   <= '0;
            state_r <= S_UDIV;
          end else begin
            if (sqv_r >= sq_trial) begin
              sqv_r   <= sqv_r - sq_trial;
              sqres_r <= (sqres_r >> 1) + sqbit_r;
            end else begin
              sqres_r <= sqres_r >> 1;
            end
            sqbit_r <= sqbit_r >> 2;
          end
        end
        S_UDIV: state_r <= S_UWAIT;
        S_UWAIT: begin
          if (div_done) begin
            umag_r[idx_r] <= div_quo[30:0];
            if (idx_r == 2'd2) begin
              fu_acc_r <= '0;
              idx_r    <= '0;
              state_r  <= S_FU_MUL;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_UDIV;
            end
          end
        end
        S_FU_MUL: state_r <= S_FU_ACC;
        S_FU_ACC: begin
          fu_acc_r <= (f_r[idx_r][DW-1] ^ eneg_r[idx_r]) ? fu_acc_r - AW'(mul_p_r)
                                                         : fu_acc_r + AW'(mul_p_r);
          if (idx_r == 2'd2) begin
            state_r <= S_FU_FIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FU_MUL;
          end
        end
        S_FU_FIN: begin
          fu_mag_r <= 33'(fu_abs >> UB);
          fu_neg_r <= fu_acc_r[AW-1];
          idx_r    <= '0;
          state_r  <= S_G_MUL;
        end
        S_G_MUL: state_r <= S_G_ACC;
        S_G_ACC: begin
          g_r[idx_r] <= g_new;
          if (idx_r == 2'd2) begin
            state_r <= S_HDIV;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_G_MUL;
          end
        end
        S_HDIV: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (div_done) begin
            h_r     <= div_quo;
            idx_r   <= '0;
            state_r <= S_T_LO;
          end
        end
        S_T_LO: state_r <= S_T_HI;
        S_T_HI: begin
          plo_r   <= mul_p_r;
          state_r <= S_T_ACC;
        end
        S_T_ACC: begin
          sum_r[idx_r] <= sum_new;
          if (tclip || sovf) clip_seen_r <= 1'b1;
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= last_r ? S_V_LO : S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_T_LO;
          end
        end
        S_V_LO: state_r <= S_V_HI;
        S_V_HI: begin
          plo_r   <= mul_p_r;
          state_r <= S_V_ACC;
        end
        S_V_ACC: begin
          vel_r[idx_r] <= vel_new;
          if (vclip) clip_seen_r <= 1'b1;
          if (idx_r == 2'd2) begin
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_V_LO;
          end
        end
        S_EMIT: begin
          // Hand the result to the output register once it is free, then
          // start a fresh sum.
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r     <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              vout_r[i] <= vel_r[i];
              sum_r[i]  <= '0;
            end
            sat_out_r       <= clip_seen_r;
            zd_out_r        <= coincide_seen_r;
            clip_seen_r     <= 1'b0;
            coincide_seen_r <= 1'b0;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.vel_x         = vout_r[0];
  assign out_chan.vel_y         = vout_r[1];
  assign out_chan.vel_z         = vout_r[2];
  assign out_chan.saturated     = sat_out_r;
  assign out_chan.zero_distance = zd_out_r;

endmodule

/* design/sds_checker.sv */
// Port-level checks for the stokeslet direct-sum core, bound to its top level.
// Depends on sds_pkg and stokeslet_direct_sum_core.
module sds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sds_pkg::VEL_W-1:0]  out_vel_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_vel_x))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("core took a second point while one was in work");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind stokeslet_direct_sum_core sds_checker u_sds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_vel_x (out_chan.vel_x)
);
